[src/mdu_pkg.sv]
package mdu_pkg;

    // Access kinds on the item channel.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Write address map.
    localparam logic [3:0] ADDR_OPERAND_LAST = 4'd3;
    localparam logic [3:0] ADDR_MUL_LO       = 4'd4;
    localparam logic [3:0] ADDR_MUL_HI       = 4'd5;
    localparam logic [3:0] ADDR_DIV_LO       = 4'd6;
    localparam logic [3:0] ADDR_DIV_HI       = 4'd7;

    // Result window.
    localparam logic [3:0] READ_BASE_LOW  = 4'd0;
    localparam logic [3:0] READ_BASE_HIGH = 4'd8;
    localparam logic [3:0] RESULT_BYTES   = 4'd6;

    // Configuration register indexes.
    localparam logic CFG_REMAINDER_QUIRK  = 1'b0;
    localparam logic CFG_READ_WINDOW_HIGH = 1'b1;

    // Last step index of each loop of the shared adder.
    localparam logic [4:0] MUL_LAST_STEP = 5'd15;
    localparam logic [4:0] DIV_LAST_STEP = 5'd31;

endpackage

[src/bus_mapped_mul_div_unit.sv]
// Every bus word is loaded into the output register in the cycle after it is accepted.
// A read or plain write frees the input again at once unless the output stalls; a write
// that starts a multiply or a divide holds the input until the loop has finished, run by
// the single 33-bit adder/subtractor that does one multiply or divide bit per cycle.
// Reset (rst_n low, asynchronous) clears all operand, result and config registers.
module bus_mapped_mul_div_unit
    import mdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [3:0] addr,
    input  logic [7:0] wdata,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] rdata,
    output logic       bad_access,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_wdata
);

    // The sequencer. MUL runs 16 shift-and-add steps, DIV runs 32 restoring
    // subtract steps, and FIN finishes a divide: it applies the odd remainder
    // quirk with the same adder and stores quotient and remainder.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t           state_reg;
    logic [4:0]       step_reg;

    logic [3:0][7:0]  operand_reg;
    logic [15:0]      multiplier_reg;
    logic [15:0]      divisor_reg;
    logic [5:0][7:0]  result_reg;
    logic             quirk_reg;
    logic             window_reg;

    // Working registers of the iteration. During a multiply acc_reg holds the
    // upper partial product and shq_reg[15:0] the multiplier shifting out while
    // product bits shift in. During a divide acc_reg holds the partial
    // remainder and shq_reg the dividend shifting out while quotient bits
    // shift in.
    logic [16:0]      acc_reg;
    logic [31:0]      shq_reg;

    logic             out_valid_reg;
    logic [7:0]       rdata_reg;
    logic             bad_reg;

    // Shared adder/subtractor.
    logic [31:0]      alu_a;
    logic [31:0]      alu_b;
    logic             alu_sub;
    logic [32:0]      alu_sum;

    logic             out_free;
    logic             accept;
    logic [16:0]      trial;
    logic             div_ge;
    logic [3:0]       read_base;
    logic [3:0]       read_rel;
    logic             read_hit;
    logic [15:0]      remainder_final;

    // The output register can take a new word when it is empty or being
    // drained this cycle, so a read waits on the consumer only while it is full and stalled.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign trial = {acc_reg[15:0], shq_reg[31]};

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_MUL:
            begin
                alu_a = {16'd0, acc_reg[15:0]};
                alu_b = shq_reg[0] ? {16'd0, operand_reg[1], operand_reg[0]} : 32'd0;
            end
            ST_DIV:
            begin
                alu_a   = {15'd0, trial};
                alu_b   = {16'd0, divisor_reg};
                alu_sub = 1'b1;
            end
            ST_FIN:
            begin
                alu_a = shq_reg;
                alu_b = {16'd0, acc_reg[15:0]};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {32'd0, alu_sub};

    // On subtract the carry out says the trial value reached the divisor.
    // With a zero divisor it is always set, which gives the all-ones quotient
    // and leaves the low dividend half in the remainder as required.
    assign div_ge = alu_sum[32];

    // An odd remainder under the quirk becomes half of remainder plus
    // quotient, taken modulo 2^32 before the halving.
    assign remainder_final = (quirk_reg && acc_reg[0]) ? alu_sum[16:1] : acc_reg[15:0];

    assign read_base = window_reg ? READ_BASE_HIGH : READ_BASE_LOW;
    assign read_rel  = addr - read_base;
    assign read_hit  = (addr >= read_base) && (read_rel < RESULT_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            operand_reg    <= '0;
            multiplier_reg <= '0;
            divisor_reg    <= '0;
            result_reg     <= '0;
            quirk_reg      <= 1'b0;
            window_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            acc_reg        <= '0;
            shq_reg        <= '0;
            rdata_reg      <= '0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_REMAINDER_QUIRK)
                begin
                    quirk_reg <= cfg_wdata;
                end
                else
                begin
                    window_reg <= cfg_wdata;
                end
            end

            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        rdata_reg <= '0;
                        bad_reg   <= 1'b0;
                        if (op == OP_WRITE)
                        begin
                            if (addr[3])
                            begin
                                bad_reg <= 1'b1;
                            end
                            else if (addr <= ADDR_OPERAND_LAST)
                            begin
                                operand_reg[addr[1:0]] <= wdata;
                            end
                            else if (addr == ADDR_MUL_LO)
                            begin
                                multiplier_reg[7:0] <= wdata;
                            end
                            else if (addr == ADDR_MUL_HI)
                            begin
                                multiplier_reg[15:8] <= wdata;
                                acc_reg              <= '0;
                                shq_reg              <= {16'd0, wdata, multiplier_reg[7:0]};
                                state_reg            <= ST_MUL;
                            end
                            else if (addr == ADDR_DIV_LO)
                            begin
                                divisor_reg[7:0] <= wdata;
                            end
                            else
                            begin
                                divisor_reg[15:8] <= wdata;
                                acc_reg           <= '0;
                                shq_reg           <= operand_reg;
                                state_reg         <= ST_DIV;
                            end
                        end
                        else if (read_hit)
                        begin
                            rdata_reg <= result_reg[read_rel[2:0]];
                        end
                        else
                        begin
                            bad_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL:
                begin
                    acc_reg       <= {1'b0, alu_sum[16:1]};
                    shq_reg[15:0] <= {alu_sum[0], shq_reg[15:1]};
                    step_reg      <= step_reg + 5'd1;
                    if (step_reg == MUL_LAST_STEP)
                    begin
                        result_reg[3:0] <= {alu_sum[16:0], shq_reg[15:1]};
                        step_reg        <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    acc_reg  <= div_ge ? alu_sum[16:0] : trial;
                    shq_reg  <= {shq_reg[30:0], div_ge};
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == DIV_LAST_STEP)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    result_reg <= {remainder_final, shq_reg};
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign rdata      = rdata_reg;
    assign bad_access = bad_reg;

    // No new bus word may enter while the adder loop is running.
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input accepted while an operation is running");

    // The step counter starts every operation from zero.
    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> (state_reg != ST_IDLE) |-> (step_reg == 5'd0))
        else $error("operation started with a stale step count");

    // A write to the divisor high byte launches the divide loop.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_WRITE && addr == ADDR_DIV_HI) |=> (state_reg == ST_DIV))
        else $error("divide did not start");

    // A write to the multiplier high byte launches the multiply loop.
    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_WRITE && addr == ADDR_MUL_HI) |=> (state_reg == ST_MUL))
        else $error("multiply did not start");

    // Every accepted bus word yields a word in the output register.
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no answer");

endmodule

[verif/mul_div_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the multiply/divide unit and keeps its own copy of
// the registers. It works out the reply for each word the unit takes in, then
// compares each word the unit hands out with the oldest reply still due.
module mul_div_checker
    import mdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [3:0]  addr,
    input  logic [7:0]  wdata,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  rdata,
    input  logic        bad_access,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_wdata,
    output int unsigned error_count,
    output int unsigned replies_due
);

    typedef struct packed {
        logic [7:0] rdata;
        logic       bad_access;
    } bus_reply_t;

    logic [31:0] operand_q;
    logic [15:0] multiplier_q;
    logic [15:0] divisor_q;
    logic [47:0] result_q;
    logic        quirk_on;
    logic        window_high;

    bus_reply_t awaited_replies[$];

    // Applies one bus access to the register copy and returns the reply.
    function automatic bus_reply_t compute_bus_reply(input logic is_write,
                                                     input logic [3:0] a,
                                                     input logic [7:0] d);
        bus_reply_t  reply;
        logic [3:0]  base;
        logic [31:0] quotient;
        logic [31:0] remainder;
        logic [31:0] sum;
        reply = '0;
        base = window_high ? READ_BASE_HIGH : READ_BASE_LOW;
        if (is_write == OP_WRITE) begin
            if (a <= ADDR_OPERAND_LAST) begin
                operand_q[int'(a) * 8 +: 8] = d;
            end
            else if (a <= ADDR_MUL_HI) begin
                multiplier_q[int'(a - ADDR_MUL_LO) * 8 +: 8] = d;
                if (a == ADDR_MUL_HI)
                    result_q[31:0] = 32'(multiplier_q) * 32'(operand_q[15:0]);
            end
            else if (a <= ADDR_DIV_HI) begin
                divisor_q[int'(a - ADDR_DIV_LO) * 8 +: 8] = d;
                if (a == ADDR_DIV_HI) begin
                    if (divisor_q == '0) begin
                        quotient  = '1;
                        remainder = 32'(operand_q[15:0]);
                    end
                    else begin
                        quotient  = operand_q / 32'(divisor_q);
                        remainder = operand_q % 32'(divisor_q);
                    end
                    if (quirk_on && remainder[0]) begin
                        sum       = remainder + quotient;
                        remainder = sum >> 1;
                    end
                    result_q = {remainder[15:0], quotient};
                end
            end
            else begin
                reply.bad_access = 1'b1;
            end
        end
        else if (a >= base && (a - base) < RESULT_BYTES) begin
            reply.rdata = result_q[int'(a - base) * 8 +: 8];
        end
        else begin
            reply.bad_access = 1'b1;
        end
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        bus_reply_t oldest;
        if (!rst_n) begin
            operand_q    = '0;
            multiplier_q = '0;
            divisor_q    = '0;
            result_q     = '0;
            quirk_on     = 1'b0;
            window_high  = 1'b0;
            error_count  = 0;
            awaited_replies.delete();
            replies_due  = 0;
        end
        else begin
            // A word cannot leave before the cycle after its access, so the outgoing
            // word is checked before this edge's access is added.
            if (out_valid && !out_stall) begin
                if (awaited_replies.size() == 0) begin
                    error_count++;
                    $error("rdata/bad_access: unexpected word, rdata %02h bad_access %0b",
                           rdata, bad_access);
                end
                else begin
                    oldest = awaited_replies.pop_front();
                    if (rdata !== oldest.rdata) begin
                        error_count++;
                        $error("rdata: expected %02h, actual %02h", oldest.rdata, rdata);
                    end
                    if (bad_access !== oldest.bad_access) begin
                        error_count++;
                        $error("bad_access: expected %0b, actual %0b",
                               oldest.bad_access, bad_access);
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_replies.push_back(compute_bus_reply(op, addr, wdata));
            if (cfg_we) begin
                if (cfg_index == CFG_REMAINDER_QUIRK)
                    quirk_on = cfg_wdata;
                else
                    window_high = cfg_wdata;
            end
            replies_due = awaited_replies.size();
        end
    end

endmodule

[verif/tb_bus_mapped_mul_div_unit.sv]
`timescale 1ns / 100ps

// Top of the bench for the multiply/divide unit. This module only makes
// stimulus and gives the verdict; the checker beside the unit predicts every
// reply word and counts mismatches.
module tb_bus_mapped_mul_div_unit;
    import mdu_pkg::*;

    // Roughly how many access words the whole run sends.
    localparam int unsigned ITEM_TARGET = 1150;
    // Random phases, each with its own register setting.
    localparam int unsigned PHASES = 5;
    // Cycles with no handshake at all before the run is called hung. This leaves a
    // wide margin over the time a divide holds the input and over the longest
    // output stall burst.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Highest address on the bus, used for out-of-range accesses.
    localparam logic [3:0] ADDR_TOP = 4'hF;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [3:0] addr;
    logic [7:0] wdata;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] rdata;
    logic       bad_access;
    logic       cfg_we;
    logic       cfg_index;
    logic       cfg_wdata;

    int unsigned error_count;
    int unsigned replies_due;
    int unsigned words_sent = 0;

    // Random idling on both channels; cleared for the last phase.
    bit idling_on = 1'b1;
    // Mirror of the read window setting, so reads can aim inside it.
    bit window_high = 1'b0;

    bus_mapped_mul_div_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .addr       (addr),
        .wdata      (wdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rdata      (rdata),
        .bad_access (bad_access),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    mul_div_checker reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .addr        (addr),
        .wdata       (wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rdata       (rdata),
        .bad_access  (bad_access),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .error_count (error_count),
        .replies_due (replies_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The watchdog restarts its count on every handshake. If the unit stops
    // taking or giving words for too long, the run ends as a failure.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_bus_mapped_mul_div_unit: done, errors");
        $finish;
    end

    // The output side stalls in random bursts, with stall-free runs of random length
    // in between. Changes happen on the falling edge only.
    initial
    begin : reply_stall
        int unsigned stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idling_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 15);
            out_stall <= (stall_left > 0);
        end
    end

    // Byte values lean toward the edges: zero, one and all ones turn up often
    // so that divide by zero, divide by one and the largest products get hit.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Sends one access word. It may first idle for a burst, then holds the
    // word until the unit takes it, and returns on the next falling edge with
    // valid still high so back-to-back words need no extra assignment.
    task automatic send_word(input logic is_write, input logic [3:0] a,
                             input logic [7:0] d);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= is_write;
        addr     <= a;
        wdata    <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Reads one result byte inside the current read window.
    task automatic read_result(input logic [3:0] index);
        send_word(OP_READ, (window_high ? READ_BASE_HIGH : READ_BASE_LOW) + index,
                  rand_byte());
    endtask

    // Writes all four operand bytes, low byte first.
    task automatic load_operand(input logic [31:0] value);
        for (int i = 0; i <= ADDR_OPERAND_LAST; i++)
            send_word(OP_WRITE, 4'(i), value[i * 8 +: 8]);
    endtask

    // Holds the sender off until every reply word has come back and the unit
    // has finished any multiply or divide still running, then lets a few more
    // cycles go by.
    task automatic drain_replies();
        in_valid <= 1'b0;
        wait (replies_due == 0 && !in_stall);
        repeat (4) @(negedge clk);
    endtask

    // Writes both registers, one per cycle. Only called while the unit is idle.
    task automatic write_settings(input logic quirk, input logic window);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REMAINDER_QUIRK;
        cfg_wdata <= quirk;
        @(negedge clk);
        cfg_index <= CFG_READ_WINDOW_HIGH;
        cfg_wdata <= window;
        @(negedge clk);
        cfg_we <= 1'b0;
        window_high = window;
    endtask

    // A well-formed burst the way software would use the unit: touch some
    // operand bytes, start a multiply or a divide, then read results back.
    // Divisor high bytes are mostly zero so small divisors and divide by zero
    // come up often.
    task automatic run_compute_burst();
        int unsigned operand_writes;
        int unsigned result_reads;
        operand_writes = $urandom_range(0, 4);
        repeat (operand_writes)
            send_word(OP_WRITE, 4'($urandom_range(0, ADDR_OPERAND_LAST)), rand_byte());
        if ($urandom_range(0, 1))
        begin
            if ($urandom_range(0, 3) != 0)
                send_word(OP_WRITE, ADDR_MUL_LO, rand_byte());
            send_word(OP_WRITE, ADDR_MUL_HI, rand_byte());
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
                send_word(OP_WRITE, ADDR_DIV_LO, rand_byte());
            send_word(OP_WRITE, ADDR_DIV_HI,
                      ($urandom_range(0, 2) == 0) ? rand_byte() : 8'h00);
        end
        result_reads = $urandom_range(1, 6);
        repeat (result_reads)
            read_result(4'($urandom_range(0, RESULT_BYTES - 1)));
    endtask

    initial
    begin : stimulus
        int unsigned phase_end;
        logic        quirk;
        logic        window;
        in_valid  = 1'b0;
        op        = OP_READ;
        addr      = '0;
        wdata     = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_REMAINDER_QUIRK;
        cfg_wdata = 1'b0;
        rst_n     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset settings: largest multiply. Result bytes 4 and
        // 5 must still hold their reset value after a multiply.
        load_operand(32'hFFFF_FFFF);
        send_word(OP_WRITE, ADDR_MUL_LO, 8'hFF);
        send_word(OP_WRITE, ADDR_MUL_HI, 8'hFF);
        read_result(4'd0);
        read_result(4'd3);
        read_result(4'd4);

        // Divide by zero: all-ones quotient, remainder from the operand's low half.
        send_word(OP_WRITE, ADDR_DIV_LO, 8'h00);
        send_word(OP_WRITE, ADDR_DIV_HI, 8'h00);
        read_result(4'd4);
        read_result(4'd0);

        // Writes past the divisor and reads past the result window are flagged.
        send_word(OP_WRITE, ADDR_DIV_HI + 4'd1, 8'hA5);
        send_word(OP_WRITE, ADDR_TOP, 8'h5A);
        send_word(OP_READ, READ_BASE_LOW + RESULT_BYTES, 8'h00);
        send_word(OP_READ, ADDR_TOP, 8'hFF);

        // Quirk on and the high window: 7 / 2 leaves an odd remainder of 1,
        // which the quirk turns into (1 + 3) / 2. The low window is now bad.
        drain_replies();
        write_settings(1'b1, 1'b1);
        load_operand(32'h0000_0007);
        send_word(OP_WRITE, ADDR_DIV_LO, 8'h02);
        send_word(OP_WRITE, ADDR_DIV_HI, 8'h00);
        read_result(4'd4);
        read_result(4'd0);
        send_word(OP_READ, READ_BASE_LOW, 8'h00);
        send_word(OP_READ, READ_BASE_HIGH + RESULT_BYTES, 8'h00);

        // Random phases walk through every register setting, the last one at
        // random. Each phase starts from an idle unit, which also means the
        // sender waits for all replies several times over the run.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_replies();
            if (p == PHASES - 1)
            begin
                idling_on = 1'b0;
                quirk  = 1'($urandom_range(0, 1));
                window = 1'($urandom_range(0, 1));
            end
            else
            begin
                quirk  = 1'(p % 2);
                window = 1'(p / 2);
            end
            write_settings(quirk, window);
            phase_end = words_sent + (ITEM_TARGET - words_sent) / (PHASES - p);
            while (words_sent < phase_end)
            begin
                // Mostly real compute bursts; the rest is raw bus noise that
                // covers every address, both access kinds and any data byte.
                if ($urandom_range(0, 9) < 7)
                    run_compute_burst();
                else
                    send_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                              8'($urandom));
            end
        end

        drain_replies();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("tb_bus_mapped_mul_div_unit: done, clean");
        else
            $display("tb_bus_mapped_mul_div_unit: done, errors");
        $finish;
    end

endmodule

[filelist.f]
src/mdu_pkg.sv
src/bus_mapped_mul_div_unit.sv
verif/mul_div_checker.sv
verif/tb_bus_mapped_mul_div_unit.sv
